// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define APWM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define APWM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define APWM_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/apwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apwm_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int SUM_W       = LEN_W + 1;
   localparam int PRE_LVLS    = $clog2(MAX_PATTERN + 1);
   localparam int BYTE_W      = 8;
   localparam int CNT_W       = 32;
   localparam int CSR_W       = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int PAT_W       = 128;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DISTANCE  = 2'd3;

   typedef struct packed {
      logic             shift;
      logic             init;
      logic             col;
      logic             emit;
      logic             last;
      logic             clr_cnt;
      logic [LEN_W-1:0] k;
      logic [LEN_W-1:0] x;
   } apwm_cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] eff_len;
   } apwm_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/apwm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apwm_dp
   import apwm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire logic [BYTE_W-1:0]    in_byte,
   input  wire apwm_cmd_type         cmd,
   output apwm_status_type           status,
   output logic [LEN_W-1:0]          res_dist,
   output logic                      res_hit,
   output logic [CNT_W-1:0]          res_total,
   output logic                      res_last
);

   logic [LEN_W-1:0]  plen_ff;
   logic [PAT_W-1:0]  pat_ff;
   logic [LEN_W-1:0]  maxd_ff;
   logic [BYTE_W-1:0] win_ff [0:MAX_PATTERN-1];
   logic [LEN_W-1:0]  dp_ff  [0:MAX_PATTERN];
   logic [CNT_W-1:0]  cnt_ff;
   logic [LEN_W-1:0]  dist_ff;
   logic              hit_ff;
   logic [CNT_W-1:0]  total_ff;
   logic              last_ff;

   logic [IDX_W-1:0]  col_idx;
   logic [BYTE_W-1:0] col_byte;
   logic [SUM_W-1:0]  cand_up [1:MAX_PATTERN];
   logic [SUM_W-1:0]  cand_dg [1:MAX_PATTERN];
   logic [SUM_W-1:0]  scan    [0:PRE_LVLS][0:MAX_PATTERN];
   logic [LEN_W-1:0]  col_in  [0:MAX_PATTERN];
   logic [LEN_W-1:0]  cur_dist;
   logic              hit;
   logic [CNT_W-1:0]  cnt_in;

   // clamp pattern length to 1..MAX_PATTERN
   always_comb begin
      if (plen_ff == '0)
         status.eff_len = LEN_W'(1);
      else if (plen_ff > LEN_W'(MAX_PATTERN))
         status.eff_len = LEN_W'(MAX_PATTERN);
      else
         status.eff_len = plen_ff;
   end

   // text byte of column x: window slot MAX_PATTERN - k + x - 1
   assign col_idx  = IDX_W'(cmd.x - LEN_W'(1) - cmd.k);
   assign col_byte = win_ff[col_idx];

   // One DP column per cycle. Vertical dependency is solved as a prefix
   // minimum of (t[j] - j), offset by MAX_PATTERN to stay non-negative.
   always_comb begin
      scan[0][0] = SUM_W'(cmd.x) + SUM_W'(MAX_PATTERN);
      for (int j = 1; j <= MAX_PATTERN; j++) begin
         cand_up[j] = SUM_W'(dp_ff[j]) + SUM_W'(1);
         cand_dg[j] = SUM_W'(dp_ff[j-1]) +
                      SUM_W'(pat_ff[BYTE_W*(j-1) +: BYTE_W] != col_byte);
         if (cand_dg[j] < cand_up[j])
            scan[0][j] = cand_dg[j] + SUM_W'(MAX_PATTERN - j);
         else
            scan[0][j] = cand_up[j] + SUM_W'(MAX_PATTERN - j);
      end
      for (int l = 0; l < PRE_LVLS; l++) begin
         for (int y = 0; y <= MAX_PATTERN; y++) begin
            scan[l+1][y] = scan[l][y];
            if (y >= (1 << l)) begin
               if (scan[l][y - (1 << l)] < scan[l][y])
                  scan[l+1][y] = scan[l][y - (1 << l)];
            end
         end
      end
      for (int y = 0; y <= MAX_PATTERN; y++) begin
         col_in[y] = LEN_W'(scan[PRE_LVLS][y] + SUM_W'(y) - SUM_W'(MAX_PATTERN));
      end
   end

   assign cur_dist = dp_ff[cmd.k];
   assign hit      = (cur_dist <= maxd_ff);
   assign cnt_in   = (hit && (cnt_ff != '1)) ? cnt_ff + CNT_W'(1) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= LEN_W'(1);
         pat_ff  <= '0;
         maxd_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PATTERN_LEN:  plen_ff <= csr_wdata[LEN_W-1:0];
            REG_PATTERN_LOW:  pat_ff[CSR_W-1:0] <= csr_wdata;
            REG_PATTERN_HIGH: pat_ff[PAT_W-1:CSR_W] <= csr_wdata;
            REG_MAX_DISTANCE: maxd_ff <= csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PATTERN; i++) win_ff[i] <= '0;
      end else if (cmd.shift) begin
         for (int i = 0; i < MAX_PATTERN - 1; i++) win_ff[i] <= win_ff[i+1];
         win_ff[MAX_PATTERN-1] <= in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         for (int y = 0; y <= MAX_PATTERN; y++) dp_ff[y] <= LEN_W'(y);
      end else if (cmd.col) begin
         for (int y = 0; y <= MAX_PATTERN; y++) dp_ff[y] <= col_in[y];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.emit) begin
         cnt_ff <= cmd.clr_cnt ? '0 : cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         dist_ff  <= cur_dist;
         hit_ff   <= hit;
         total_ff <= cnt_in;
         last_ff  <= cmd.last;
      end
   end

   assign res_dist  = dist_ff;
   assign res_hit   = hit_ff;
   assign res_total = total_ff;
   assign res_last  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/apwm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apwm_ctrl
   import apwm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   input  wire logic            req_tlast,
   output logic                 req_tready,
   input  wire logic            rsp_tready,
   output logic                 rsp_tvalid,
   input  wire apwm_status_type status,
   output apwm_cmd_type         cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_COL  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] x_ff, x_in;
   logic             eot_ff, eot_in;
   logic             valid_ff, valid_in;
   logic [LEN_W-1:0] fill_new;
   logic             out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = !valid_ff || rsp_tready;
   assign fill_new   = (fill_ff < LEN_W'(MAX_PATTERN)) ? fill_ff + LEN_W'(1) : fill_ff;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      k_in        = k_ff;
      x_in        = x_ff;
      eot_in      = eot_ff;
      valid_in    = valid_ff && !rsp_tready;
      cmd         = '0;
      cmd.k       = k_ff;
      cmd.x       = x_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.shift = 1'b1;
               cmd.init  = 1'b1;
               x_in      = LEN_W'(1);
               fill_in   = fill_new;
               if (req_tlast) begin
                  fill_in  = '0;
                  eot_in   = 1'b1;
                  k_in     = (fill_new < status.eff_len) ? fill_new : status.eff_len;
                  state_in = S_COL;
               end else if (fill_new >= status.eff_len) begin
                  eot_in   = 1'b0;
                  k_in     = status.eff_len;
                  state_in = S_COL;
               end
            end
         end
         S_COL: begin
            cmd.col = 1'b1;
            if (x_ff == k_ff)
               state_in = S_EMIT;
            else
               x_in = x_ff + LEN_W'(1);
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.last = eot_ff && (k_ff == LEN_W'(1));
               valid_in = 1'b1;
               if (eot_ff && (k_ff != LEN_W'(1))) begin
                  k_in     = k_ff - LEN_W'(1);
                  x_in     = LEN_W'(1);
                  cmd.init = 1'b1;
                  state_in = S_COL;
               end else begin
                  cmd.clr_cnt = eot_ff;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         k_ff     <= '0;
         x_ff     <= '0;
         eot_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         k_ff     <= k_in;
         x_ff     <= x_in;
         eot_ff   <= eot_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/approx_pattern_window_match.sv =====
// A byte that completes a length-L window is taken in idle (window shift, DP init); the DP then
// updates one column per cycle for columns 1..L, and the result register loads once rsp is free.
// No new byte is taken until the last result is loaded; one byte per cycle while the window is
// still filling. An end-of-text byte scores tails k = min(fill, L) down to 1 in turn, a DP pass each.
// Reset (synchronous, active high): clears window, fill, match count and output valid;
// pattern length returns to 1, pattern characters and max distance to 0.
`timescale 1ns / 1ps
`default_nettype none

module approx_pattern_window_match
   import apwm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // text in
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] text_byte
   input  wire logic                 req_tlast,   // end_of_text
   // match results out
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [39:0]               rsp_tdata,   // [4:0] edit_distance, [5] is_match,
                                                  // [37:6] match_total, [39:38] zero
   output logic                      rsp_tlast,   // last_result
   // register writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   apwm_cmd_type     cmd;
   apwm_status_type  status;
   logic [LEN_W-1:0] res_dist;
   logic             res_hit;
   logic [CNT_W-1:0] res_total;
   logic             res_last;

   // Sequencer: accepts a transaction only when idle, then walks the
   // columns of each DP pass and hands results to the output register.
   apwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: config registers, sliding window, DP column,
   // saturating match counter and result register.
   apwm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_byte   (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .res_dist  (res_dist),
      .res_hit   (res_hit),
      .res_total (res_total),
      .res_last  (res_last)
   );

   // pack result fields, low field first, zero fill to a byte boundary
   assign rsp_tdata = {2'b00, res_total, res_hit, res_dist};
   assign rsp_tlast = res_last;

endmodule

`default_nettype wire

// ===== rtl/core/apwm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module apwm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   `APWM_ASSERT_ALWAYS(a_reset_clears_rsp, reset, !rsp_tvalid, "rsp valid after reset")
   `APWM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled rsp changed")
   `APWM_ASSERT_NOW(a_dist_range, rsp_tvalid, rsp_tdata[4:0] <= 5'd16, "distance above pattern size")
   `APWM_ASSERT_NOW(a_match_counted, rsp_tvalid && rsp_tdata[5], rsp_tdata[37:6] != 32'd0, "match without count")

endmodule

bind approx_pattern_window_match apwm_checker u_apwm_checker (.*);

`default_nettype wire
